>>> hw/rtl/epp_pkg.sv
// ============================================================================
// epp_pkg - shared constants and helpers for the encoder position PID
// Widths of the shared multiply and divide units, register codes and
// the signed 32-bit saturation helper.
// ============================================================================
`default_nettype none

package epp_pkg;

    // Defaults for the top-level parameters
    localparam int FRAC_BITS_DEF      = 16;
    localparam int INTEGRAL_WIDTH_DEF = 48;

    // Field and register widths
    localparam int DATA_W     = 32;
    localparam int ELAPSED_W  = 16;
    localparam int PULSE_W    = 16;
    localparam int CFG_IDX_W  = 3;

    // Milliseconds per second, used for rate and time scaling
    localparam int MS_PER_S   = 1000;

    // err * elapsed_ms fits in this many signed bits
    localparam int INC_W      = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPP    = 3'd4;

    // Digit-serial multiplier: 32-bit operand times 64-bit operand
    localparam int MAC_A_W    = 32;
    localparam int MAC_B_W    = 64;
    localparam int MAC_DIG_W  = 16;
    localparam int MAC_DIGITS = MAC_B_W / MAC_DIG_W;
    localparam int MAC_CNT_W  = $clog2(MAC_DIGITS);
    localparam int MAC_PP_W   = MAC_A_W + MAC_DIG_W + 1;
    localparam int MAC_P_W    = MAC_A_W + MAC_B_W;

    // Drive sum holds three shifted products exactly
    localparam int SUM_W      = MAC_P_W + 2;

    // Radix-16 divider: 64-bit dividend, 16-bit divisor
    localparam int DIV_N_W    = 64;
    localparam int DIV_D_W    = 16;
    localparam int DIV_STEP   = 4;
    localparam int DIV_ITER   = DIV_N_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_ITER);

    // Saturation bounds
    localparam logic signed [DATA_W-1:0] SAT32_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] SAT32_MIN = 32'sh8000_0000;

    // Clamp a sign-extended value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [127:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[127:DATA_W-1] == {(128-DATA_W+1){v[127]}}) begin
            r = v[DATA_W-1:0];
        end else if (v[127]) begin
            r = SAT32_MIN;
        end else begin
            r = SAT32_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/epp_mac.sv
// ============================================================================
// epp_mac - digit-serial signed multiplier
// Multiplies a signed 32-bit operand by a signed 64-bit operand, one
// 16-bit digit per cycle, most significant digit first.
// ============================================================================
`default_nettype none

module epp_mac (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      start,
    input  wire logic signed [epp_pkg::MAC_A_W-1:0]        op_a,
    input  wire logic signed [epp_pkg::MAC_B_W-1:0]        op_b,
    output logic                                           done,
    output logic signed [epp_pkg::MAC_P_W-1:0]             prod
);

    logic signed [epp_pkg::MAC_A_W-1:0]   a_reg, a_next;
    logic        [epp_pkg::MAC_B_W-1:0]   b_reg, b_next;
    logic signed [epp_pkg::MAC_P_W-1:0]   acc_reg, acc_next;
    logic        [epp_pkg::MAC_CNT_W-1:0] cnt_reg, cnt_next;
    logic                                 busy_reg, busy_next;
    logic                                 done_reg, done_next;

    logic                                 first;
    logic        [epp_pkg::MAC_DIG_W-1:0] digit;
    logic signed [epp_pkg::MAC_DIG_W:0]   digit_ext;
    logic signed [epp_pkg::MAC_PP_W-1:0]  pp;
    logic signed [epp_pkg::MAC_P_W-1:0]   acc_step;

    // One partial product; the top digit carries the sign
    always_comb begin
        first     = (cnt_reg == epp_pkg::MAC_CNT_W'(epp_pkg::MAC_DIGITS - 1));
        digit     = b_reg[epp_pkg::MAC_B_W-1 -: epp_pkg::MAC_DIG_W];
        digit_ext = first ? {digit[epp_pkg::MAC_DIG_W-1], digit} : {1'b0, digit};
        pp        = a_reg * digit_ext;
        acc_step  = first ? epp_pkg::MAC_P_W'(pp)
                          : (acc_reg <<< epp_pkg::MAC_DIG_W) + epp_pkg::MAC_P_W'(pp);
    end

    // Sequencing
    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = op_a;
            b_next    = op_b;
            cnt_next  = epp_pkg::MAC_CNT_W'(epp_pkg::MAC_DIGITS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = acc_step;
            b_next   = b_reg << epp_pkg::MAC_DIG_W;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

>>> hw/rtl/epp_div.sv
// ============================================================================
// epp_div - iterative signed divider
// Divides a signed 64-bit dividend by an unsigned nonzero 16-bit divisor,
// four quotient bits per cycle, truncating toward zero.
// ============================================================================
`default_nettype none

module epp_div (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic signed [epp_pkg::DIV_N_W-1:0]    dividend,
    input  wire logic        [epp_pkg::DIV_D_W-1:0]    divisor,
    output logic                                       done,
    output logic signed [epp_pkg::DIV_N_W-1:0]         quotient
);

    logic        [epp_pkg::DIV_N_W-1:0]   q_reg, q_next;
    logic        [epp_pkg::DIV_D_W-1:0]   rem_reg, rem_next;
    logic        [epp_pkg::DIV_D_W-1:0]   den_reg, den_next;
    logic signed [epp_pkg::DIV_N_W-1:0]   quo_reg, quo_next;
    logic                                 neg_reg, neg_next;
    logic        [epp_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                                 busy_reg, busy_next;
    logic                                 fix_reg, fix_next;
    logic                                 done_reg, done_next;

    logic        [epp_pkg::DIV_D_W:0]     r;
    logic        [epp_pkg::DIV_N_W-1:0]   q;

    // Restoring division, several bits per cycle on the magnitude
    always_comb begin
        r = {1'b0, rem_reg};
        q = q_reg;
        for (int i = 0; i < epp_pkg::DIV_STEP; i++) begin
            r = {r[epp_pkg::DIV_D_W-1:0], q[epp_pkg::DIV_N_W-1]};
            q = {q[epp_pkg::DIV_N_W-2:0], 1'b0};
            if (r >= {1'b0, den_reg}) begin
                r    = r - {1'b0, den_reg};
                q[0] = 1'b1;
            end
        end
    end

    // Sequencing: load magnitude, iterate, restore sign
    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        if (start) begin
            neg_next  = dividend[epp_pkg::DIV_N_W-1];
            q_next    = dividend[epp_pkg::DIV_N_W-1] ? -dividend : dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = epp_pkg::DIV_CNT_W'(epp_pkg::DIV_ITER - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = q;
            rem_next = r[epp_pkg::DIV_D_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end else if (fix_reg) begin
            quo_next  = neg_reg ? -q_reg : q_reg;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hw/rtl/encoder_position_pid.sv
// ============================================================================
// encoder_position_pid - fixed-point PID position controller
// Accumulates encoder pulses, forms position, error, integral and
// derivative, and computes a saturated Q-format drive command per tick.
// ============================================================================
// Usage:
//   s_tdata carries one control tick (elapsed ms, signed pulse count).
//   A tick with zero elapsed time is taken and dropped: no result, no
//   state change. Every other tick yields one result transaction on m_*.
//   cfg_* writes the gains, target and units-per-pulse; write only while
//   no tick is in flight. cfg_ready is always high; unknown indexes are
//   ignored.
//   Six multiply steps (launch, four 16-bit digits, handoff) and three
//   divide steps (launch, sixteen 4-bit iterations, sign fix, handoff)
//   run in sequence on the shared units, then the output register loads.
//   s_tready is high only while the sequencer is idle, so a new tick is
//   taken only once the previous result has left the sequencer.
//   The result sits in an output register; the next tick is accepted while
//   it waits. If the receiver stalls, the finished next result holds in
//   the sequencer until the output register frees.
//   Reset (aresetn low, synchronous) clears registers, pulse count,
//   integral and previous error, and drops any pending result.
// ============================================================================
`default_nettype none

module encoder_position_pid #(
    parameter int FRAC_BITS      = epp_pkg::FRAC_BITS_DEF,
    parameter int INTEGRAL_WIDTH = epp_pkg::INTEGRAL_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Tick input
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,   // elapsed_ms, pulse_increment
    // Result output
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [127:0]                           m_tdata,   // drive_command,
                                                              // measured_velocity,
                                                              // current_position,
                                                              // position_error
    // Configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [epp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [epp_pkg::DATA_W-1:0]        cfg_data
);

    localparam int INT_SUM_W   = ((INTEGRAL_WIDTH > epp_pkg::INC_W) ?
                                  INTEGRAL_WIDTH : epp_pkg::INC_W) + 1;
    localparam int VEL_SCL_W   = 26;
    localparam int DERIV_NUM_W = 43;
    localparam int DW          = epp_pkg::DATA_W;

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_VMUL = 4'd1;
    localparam logic [3:0] ST_VDIV = 4'd2;
    localparam logic [3:0] ST_PMUL = 4'd3;
    localparam logic [3:0] ST_IMUL = 4'd4;
    localparam logic [3:0] ST_IDIV = 4'd5;
    localparam logic [3:0] ST_DDIV = 4'd6;
    localparam logic [3:0] ST_GPM  = 4'd7;
    localparam logic [3:0] ST_GIM  = 4'd8;
    localparam logic [3:0] ST_GDM  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    // Control and state registers
    logic [3:0]                          state_reg, state_next;
    logic                                mac_go_reg, mac_go_next;
    logic                                div_go_reg, div_go_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic signed [DW-1:0]                gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [DW-1:0]                target_reg, upp_reg;
    logic signed [DW-1:0]                pulse_total_reg, pulse_total_next;
    logic signed [INTEGRAL_WIDTH-1:0]    integral_reg, integral_next;
    logic signed [DW-1:0]                prev_err_reg, prev_err_next;

    // Per-tick payload
    logic [epp_pkg::ELAPSED_W-1:0]       el_reg, el_next;
    logic signed [epp_pkg::PULSE_W-1:0]  pul_reg, pul_next;
    logic signed [DW-1:0]                vel_reg, vel_next;
    logic signed [DW-1:0]                pos_reg, pos_next;
    logic signed [DW-1:0]                err_reg, err_next;
    logic signed [epp_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [127:0]                        m_tdata_reg, m_tdata_next;

    // Datapath
    logic [epp_pkg::ELAPSED_W-1:0]       s_elapsed;
    logic signed [epp_pkg::PULSE_W-1:0]  s_pulse;
    logic signed [VEL_SCL_W-1:0]         vel_scaled;
    logic signed [DW:0]                  err_diff;
    logic signed [DERIV_NUM_W-1:0]       deriv_num;
    logic signed [63:0]                  mac_lo;
    logic signed [64:0]                  pos_diff;
    logic signed [INT_SUM_W-1:0]         int_sum;
    logic signed [INTEGRAL_WIDTH-1:0]    int_sat;
    logic signed [epp_pkg::SUM_W-1:0]    sum_add;

    logic signed [epp_pkg::MAC_A_W-1:0]  mac_a;
    logic signed [epp_pkg::MAC_B_W-1:0]  mac_b;
    logic                                mac_done;
    logic signed [epp_pkg::MAC_P_W-1:0]  mac_prod;
    logic signed [epp_pkg::DIV_N_W-1:0]  div_num;
    logic [epp_pkg::DIV_D_W-1:0]         div_den;
    logic                                div_done;
    logic signed [epp_pkg::DIV_N_W-1:0]  div_quo;

    assign s_elapsed = s_tdata[15:0];
    assign s_pulse   = s_tdata[31:16];

    // Fixed scalings and differences
    always_comb begin
        vel_scaled = VEL_SCL_W'(pul_reg) * VEL_SCL_W'(epp_pkg::MS_PER_S);
        err_diff   = (DW + 1)'(err_reg) - (DW + 1)'(prev_err_reg);
        deriv_num  = DERIV_NUM_W'(err_diff) * DERIV_NUM_W'(epp_pkg::MS_PER_S);
        mac_lo     = mac_prod[63:0];
        pos_diff   = 65'(target_reg) - 65'(mac_lo);
        sum_add    = sum_reg + epp_pkg::SUM_W'(mac_prod >>> FRAC_BITS);
    end

    // Integral update with saturation to INTEGRAL_WIDTH bits
    always_comb begin
        int_sum = INT_SUM_W'(integral_reg) + INT_SUM_W'(div_quo);
        if (int_sum[INT_SUM_W-1:INTEGRAL_WIDTH-1] ==
            {(INT_SUM_W - INTEGRAL_WIDTH + 1){int_sum[INT_SUM_W-1]}}) begin
            int_sat = int_sum[INTEGRAL_WIDTH-1:0];
        end else begin
            int_sat = {int_sum[INT_SUM_W-1], {(INTEGRAL_WIDTH-1){~int_sum[INT_SUM_W-1]}}};
        end
    end

    // Operand selection for the shared multiplier and divider
    always_comb begin
        mac_a   = upp_reg;
        mac_b   = '0;
        div_num = mac_lo;
        div_den = el_reg;
        unique case (state_reg)
            ST_VMUL: mac_b = epp_pkg::MAC_B_W'(vel_scaled);
            ST_PMUL: mac_b = epp_pkg::MAC_B_W'(pulse_total_reg);
            ST_IMUL: begin
                mac_a = err_reg;
                mac_b = {{(epp_pkg::MAC_B_W - epp_pkg::ELAPSED_W){1'b0}}, el_reg};
            end
            ST_IDIV: div_den = epp_pkg::DIV_D_W'(epp_pkg::MS_PER_S);
            ST_DDIV: div_num = epp_pkg::DIV_N_W'(deriv_num);
            ST_GPM: begin
                mac_a = gain_p_reg;
                mac_b = epp_pkg::MAC_B_W'(err_reg);
            end
            ST_GIM: begin
                mac_a = gain_i_reg;
                mac_b = epp_pkg::MAC_B_W'(integral_reg);
            end
            ST_GDM: begin
                mac_a = gain_d_reg;
                mac_b = div_quo;
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        mac_go_next      = 1'b0;
        div_go_next      = 1'b0;
        m_tvalid_next    = m_tvalid_reg;
        pulse_total_next = pulse_total_reg;
        integral_next    = integral_reg;
        prev_err_next    = prev_err_reg;
        el_next          = el_reg;
        pul_next         = pul_reg;
        vel_next         = vel_reg;
        pos_next         = pos_reg;
        err_next         = err_reg;
        sum_next         = sum_reg;
        m_tdata_next     = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_elapsed != '0) begin
                    el_next          = s_elapsed;
                    pul_next         = s_pulse;
                    pulse_total_next = pulse_total_reg + DW'(s_pulse);
                    mac_go_next      = 1'b1;
                    state_next       = ST_VMUL;
                end
            end
            ST_VMUL: begin
                if (mac_done) begin
                    div_go_next = 1'b1;
                    state_next  = ST_VDIV;
                end
            end
            ST_VDIV: begin
                if (div_done) begin
                    vel_next    = epp_pkg::sat32(128'(div_quo));
                    mac_go_next = 1'b1;
                    state_next  = ST_PMUL;
                end
            end
            ST_PMUL: begin
                if (mac_done) begin
                    pos_next    = epp_pkg::sat32(128'(mac_lo));
                    err_next    = epp_pkg::sat32(128'(pos_diff));
                    mac_go_next = 1'b1;
                    state_next  = ST_IMUL;
                end
            end
            ST_IMUL: begin
                if (mac_done) begin
                    div_go_next = 1'b1;
                    state_next  = ST_IDIV;
                end
            end
            ST_IDIV: begin
                if (div_done) begin
                    integral_next = int_sat;
                    div_go_next   = 1'b1;
                    state_next    = ST_DDIV;
                end
            end
            ST_DDIV: begin
                if (div_done) begin
                    prev_err_next = err_reg;
                    sum_next      = '0;
                    mac_go_next   = 1'b1;
                    state_next    = ST_GPM;
                end
            end
            ST_GPM: begin
                if (mac_done) begin
                    sum_next    = sum_add;
                    mac_go_next = 1'b1;
                    state_next  = ST_GIM;
                end
            end
            ST_GIM: begin
                if (mac_done) begin
                    sum_next    = sum_add;
                    mac_go_next = 1'b1;
                    state_next  = ST_GDM;
                end
            end
            ST_GDM: begin
                if (mac_done) begin
                    sum_next   = sum_add;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {err_reg, pos_reg, vel_reg,
                                     epp_pkg::sat32(128'(sum_reg))};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and state registers, configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            mac_go_reg      <= 1'b0;
            div_go_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            pulse_total_reg <= '0;
            integral_reg    <= '0;
            prev_err_reg    <= '0;
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            target_reg      <= '0;
            upp_reg         <= '0;
        end else begin
            state_reg       <= state_next;
            mac_go_reg      <= mac_go_next;
            div_go_reg      <= div_go_next;
            m_tvalid_reg    <= m_tvalid_next;
            pulse_total_reg <= pulse_total_next;
            integral_reg    <= integral_next;
            prev_err_reg    <= prev_err_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    epp_pkg::REG_GAIN_P: gain_p_reg <= cfg_data;
                    epp_pkg::REG_GAIN_I: gain_i_reg <= cfg_data;
                    epp_pkg::REG_GAIN_D: gain_d_reg <= cfg_data;
                    epp_pkg::REG_TARGET: target_reg <= cfg_data;
                    epp_pkg::REG_UPP:    upp_reg    <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        el_reg      <= el_next;
        pul_reg     <= pul_next;
        vel_reg     <= vel_next;
        pos_reg     <= pos_next;
        err_reg     <= err_next;
        sum_reg     <= sum_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Shared arithmetic units
    epp_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_go_reg),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .done    (mac_done),
        .prod    (mac_prod)
    );

    epp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go_reg),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // Multiplier and divider are never launched in the same cycle
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mac_go_reg && div_go_reg))
        else $error("multiplier and divider launched together");

    // Pulse count moves only on an accepted tick
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready) |=> $stable(pulse_total_reg))
        else $error("pulse count changed without a tick");

    // A new result appears only from the output step
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the output step");

    // Multiplier completion arrives only while the sequencer waits on it
    a_mac_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == ST_VMUL || state_reg == ST_PMUL ||
                      state_reg == ST_IMUL || state_reg == ST_GPM ||
                      state_reg == ST_GIM || state_reg == ST_GDM))
        else $error("multiplier finished in an unexpected state");

endmodule

`default_nettype wire

>>> verif/encoder_position_pid_checker.sv
// ============================================================================
// encoder_position_pid_checker - result checker for the encoder position PID
// Watches the tick, result and register-write channels, tracks the pulse
// count, error integral, last error and register file, predicts the four
// result fields for every tick with nonzero elapsed time, and compares each
// result transaction in order against the oldest prediction.
// ============================================================================

module encoder_position_pid_checker #(
    parameter int FRAC_W     = epp_pkg::FRAC_BITS_DEF,
    parameter int INTEGRAL_W = epp_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [31:0]                       s_tdata,    // elapsed_ms, pulse_increment
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [127:0]                      m_tdata,    // drive_command,
                                                          // measured_velocity,
                                                          // current_position,
                                                          // position_error
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [epp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [epp_pkg::DATA_W-1:0]        cfg_data,
    output int unsigned                       mismatches,
    output int unsigned                       outstanding,
    output int unsigned                       results_checked,
    output int unsigned                       ticks_dropped,
    output int unsigned                       integral_clipped
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q_MAX       = 64'sh0000_0000_7fff_ffff;
    localparam longint Q_MIN       = 64'shffff_ffff_8000_0000;
    localparam longint INTEGRAL_HI = (64'sd1 <<< (INTEGRAL_W - 1)) - 64'sd1;
    localparam longint INTEGRAL_LO = -INTEGRAL_HI - 64'sd1;

    // Tick fields, lowest bits last
    typedef struct packed {
        logic signed [15:0] pulse_increment;
        logic        [15:0] elapsed_ms;
    } tick_t;

    // Result fields, lowest bits last
    typedef struct packed {
        logic signed [31:0] position_error;
        logic signed [31:0] current_position;
        logic signed [31:0] measured_velocity;
        logic signed [31:0] drive_command;
    } pid_result_t;

    // Register file copy
    logic signed [31:0] gain_p = '0;
    logic signed [31:0] gain_i = '0;
    logic signed [31:0] gain_d = '0;
    logic signed [31:0] target_pos = '0;
    logic signed [31:0] unit_per_pulse = '0;

    // Controller state copy
    logic signed [31:0]           pulse_count = '0;
    logic signed [INTEGRAL_W-1:0] integral = '0;
    logic signed [31:0]           last_error = '0;

    pid_result_t expected_results[$];
    pid_result_t predicted, observed;
    tick_t       tick;
    int unsigned fail_total = 0;
    int unsigned checked_total = 0;
    int unsigned dropped_total = 0;
    int unsigned clipped_total = 0;

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > Q_MAX) return 32'sh7fff_ffff;
        if (v < Q_MIN) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Gain times value, fraction bits dropped with rounding toward minus infinity
    function automatic logic signed [127:0] gain_term(input logic signed [31:0] g,
                                                      input longint x);
        logic signed [127:0] gw, xw;
        gw = 128'(g);
        xw = 128'(x);
        return (gw * xw) >>> FRAC_W;
    endfunction

    // One control tick: updates the state copy, returns 0 for a dropped tick
    function automatic bit predict_tick(input logic [15:0] ms_in,
                                        input logic signed [15:0] pulses,
                                        output pid_result_t res);
        longint ms, upp, speed, pos, err, step, sum, deriv;
        logic signed [127:0] drive;
        res = '0;
        if (ms_in == '0) return 1'b0;

        ms    = longint'(ms_in);
        upp   = longint'(unit_per_pulse);
        speed = longint'(pulses) * upp * epp_pkg::MS_PER_S / ms;

        pulse_count = pulse_count + 32'(pulses);
        pos = longint'(pulse_count) * upp;
        err = longint'(clamp32(128'(longint'(target_pos) - pos)));

        // integral saturates at the signed range of its width
        step = err * ms / epp_pkg::MS_PER_S;
        sum  = longint'(integral) + step;
        if (sum > INTEGRAL_HI) sum = INTEGRAL_HI;
        else if (sum < INTEGRAL_LO) sum = INTEGRAL_LO;
        if (sum == INTEGRAL_HI || sum == INTEGRAL_LO) clipped_total++;
        integral = INTEGRAL_W'(sum);

        deriv      = (err - longint'(last_error)) * epp_pkg::MS_PER_S / ms;
        last_error = 32'(err);

        drive = gain_term(gain_p, err) + gain_term(gain_i, sum) + gain_term(gain_d, deriv);

        res.drive_command     = clamp32(drive);
        res.measured_velocity = clamp32(128'(speed));
        res.current_position  = clamp32(128'(pos));
        res.position_error    = 32'(err);
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endtask

    // Track all three channels at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            gain_p         = '0;
            gain_i         = '0;
            gain_d         = '0;
            target_pos     = '0;
            unit_per_pulse = '0;
            pulse_count    = '0;
            integral       = '0;
            last_error     = '0;
            expected_results.delete();
        end else begin
            // result transaction against oldest prediction
            if (m_tvalid && m_tready) begin
                observed = m_tdata;
                if (expected_results.size() == 0) begin
                    $error("result transaction with no prediction pending: %h", m_tdata);
                    fail_total++;
                end else begin
                    predicted = expected_results.pop_front();
                    check_field("drive_command", predicted.drive_command,
                                observed.drive_command);
                    check_field("measured_velocity", predicted.measured_velocity,
                                observed.measured_velocity);
                    check_field("current_position", predicted.current_position,
                                observed.current_position);
                    check_field("position_error", predicted.position_error,
                                observed.position_error);
                    checked_total++;
                end
            end

            // register write; unknown indexes are ignored
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    epp_pkg::REG_GAIN_P: gain_p         = cfg_data;
                    epp_pkg::REG_GAIN_I: gain_i         = cfg_data;
                    epp_pkg::REG_GAIN_D: gain_d         = cfg_data;
                    epp_pkg::REG_TARGET: target_pos     = cfg_data;
                    epp_pkg::REG_UPP:    unit_per_pulse = cfg_data;
                    default: ;
                endcase
            end

            // tick transaction
            if (s_tvalid && s_tready) begin
                tick = s_tdata;
                if (predict_tick(tick.elapsed_ms, tick.pulse_increment, predicted)) begin
                    expected_results.push_back(predicted);
                end else begin
                    dropped_total++;
                end
            end
        end

        mismatches       <= fail_total;
        outstanding      <= expected_results.size();
        results_checked  <= checked_total;
        ticks_dropped    <= dropped_total;
        integral_clipped <= clipped_total;
    end

endmodule

>>> verif/testbench.sv
// ============================================================================
// testbench - stimulus and verdict for the encoder position PID
// Programs gains, target and units-per-pulse while the block is idle, sends
// directed corner ticks, then a long integral wind-up stretch under varying
// source and sink throttling and random ticks without throttling, and reports
// the outcome collected by the result checker.
// ============================================================================

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 128;
    localparam int HOLD_CYCLES  = 700;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata   = '0;     // elapsed_ms, pulse_increment
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [127:0] m_tdata;            // drive_command, measured_velocity,
                                      // current_position, position_error
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [epp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [epp_pkg::DATA_W-1:0]    cfg_data  = '0;

    int unsigned mismatches, outstanding, results_checked, ticks_dropped;
    int unsigned integral_clipped;

    int          tx_idle_pct  = 32;
    int          rx_idle_pct  = 82;
    bit          hold_request = 1'b0;
    int unsigned ticks_sent   = 0;
    int unsigned writes_done  = 0;

    encoder_position_pid dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    encoder_position_pid_checker pid_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .results_checked  (results_checked),
        .ticks_dropped    (ticks_dropped),
        .integral_clipped (integral_clipped)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    initial begin
        #10ms;
        $display("timeout: %0d ticks sent, %0d results pending", ticks_sent, outstanding);
        $display("*** FAILED ***");
        $finish;
    end

    // Result sink: random throttle, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // One tick transaction, with random idle cycles in front
    task automatic send_tick(input logic [15:0] ms, input logic signed [15:0] pulses);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pulses, ms};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [epp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        writes_done++;
    endtask

    // All five registers, optionally followed by writes to unused indexes
    task automatic apply_settings(input logic [31:0] gp, input logic [31:0] gi,
                                  input logic [31:0] gd, input logic [31:0] tgt,
                                  input logic [31:0] upp, input bit probe_spare);
        write_reg(epp_pkg::REG_GAIN_P, gp);
        write_reg(epp_pkg::REG_GAIN_I, gi);
        write_reg(epp_pkg::REG_GAIN_D, gd);
        write_reg(epp_pkg::REG_TARGET, tgt);
        write_reg(epp_pkg::REG_UPP, upp);
        if (probe_spare) begin
            for (int idx = int'(epp_pkg::REG_UPP) + 1; idx < 2 ** epp_pkg::CFG_IDX_W;
                 idx++) begin
                write_reg(epp_pkg::CFG_IDX_W'(idx), $urandom());
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // Wait for every predicted result, then let a dropped tick finish too
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register value: extremes, unit values, small Q values or anything
    function automatic logic [31:0] pick_q();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 32'h0000_0000;
        if (r < 15) return 32'h0001_0000;
        if (r < 20) return 32'hffff_0000;
        if (r < 25) return 32'h7fff_ffff;
        if (r < 30) return 32'h8000_0000;
        if (r < 65) return 32'($urandom_range(32'h60000) - 32'h30000);
        return $urandom();
    endfunction

    function automatic logic [15:0] pick_ms();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)  return 16'd0;
        if (r < 8)  return 16'd1;
        if (r < 12) return 16'hffff;
        if (r < 42) return 16'($urandom_range(20, 1));
        if (r < 72) return 16'($urandom_range(2000, 1));
        return 16'($urandom_range(16'hffff, 1));
    endfunction

    function automatic logic [15:0] pick_pulses();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)  return 16'h7fff;
        if (r < 10) return 16'h8000;
        if (r < 40) return 16'($urandom_range(100) - 50);
        return 16'($urandom());
    endfunction

    // Wind-up tick: long intervals, count drifting negative
    task automatic windup_tick();
        int unsigned r;
        logic [15:0] ms, pulses;
        r = $urandom_range(99);
        if (r < 2)      ms = 16'd0;
        else if (r < 5) ms = 16'($urandom_range(16'hffff, 1));
        else            ms = 16'($urandom_range(16'hffff, 63000));
        if ($urandom_range(99) < 5) pulses = 16'($urandom());
        else                        pulses = 16'($urandom_range(36768) - 32768);
        send_tick(ms, pulses);
    endtask

    // Main stimulus
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        settle();

        // Moderate gains, corner intervals and pulse counts, ignored ticks
        apply_settings(32'h0001_0000, 32'h0000_8000, 32'h0000_1000,
                       32'h000a_0000, 32'h0000_0100, 1'b1);
        send_tick(16'd0, 16'sd100);
        send_tick(16'd1, 16'sh7fff);
        send_tick(16'hffff, 16'sh8000);
        send_tick(16'd10, 16'sd0);
        send_tick(16'd0, -16'sd1);
        send_tick(16'd1000, -16'sd1);
        send_tick(16'haaaa, 16'sh5555);
        send_tick(16'h5555, 16'shaaaa);
        settle();

        // Positive extremes: velocity, position and drive all saturate
        apply_settings(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                       32'h8000_0000, 32'h7fff_ffff, 1'b1);
        send_tick(16'd1, 16'sh7fff);
        send_tick(16'd1, 16'sh8000);
        send_tick(16'hffff, 16'sh8000);
        send_tick(16'd3, 16'sd7);
        settle();

        // Negative extremes
        apply_settings(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                       32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_tick(16'd1, 16'sh7fff);
        send_tick(16'd7, -16'sd3);
        send_tick(16'hffff, 16'sd1);
        send_tick(16'd2, 16'sh8000);
        settle();

        // Negative gains and fractions: truncation and floor rounding
        apply_settings(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff,
                       32'hffff_8000, 32'hffff_0001, 1'b0);
        send_tick(16'd999, -16'sd5);
        send_tick(16'd1001, 16'sd5);
        send_tick(16'd3, -16'sd1);
        send_tick(16'd0, 16'sh7fff);
        settle();

        // Error pinned at its maximum so the integral winds up to saturation
        for (int seg = 0; seg < 8; seg++) begin
            if (seg == 4) begin
                tx_idle_pct = 82;
                rx_idle_pct = 32;
            end
            settle();
            apply_settings(pick_q(), pick_q(), pick_q(), 32'h7fff_ffff,
                           32'($urandom_range(16'h800, 1)), 1'b0);
            repeat (145) windup_tick();
        end

        // Random settings and ticks, no throttling; one long sink hold-off
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int seg = 0; seg < 4; seg++) begin
            settle();
            apply_settings(pick_q(), pick_q(), pick_q(), pick_q(), pick_q(), seg == 0);
            if (seg == 1) hold_request = 1'b1;
            repeat (60) send_tick(pick_ms(), pick_pulses());
        end
        settle();

        $display("%0d ticks sent (%0d with zero interval), %0d results checked, %0d writes",
                 ticks_sent, ticks_dropped, results_checked, writes_done);
        $display("integral held at its limit on %0d ticks", integral_clipped);
        if (mismatches == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
